// ----- hdl/efs_pkg.sv -----
// shared types and constants for the elevator floor scheduler
package efs_pkg;

  localparam int FLOOR_W        = 5;
  localparam int CMP_W          = 7;
  localparam int MAX_FLOORS_DEF = 16;
  localparam int MIN_FLOORS     = 2;

  localparam logic [FLOOR_W-1:0] FLOORS_RESET  = 5'd16;
  localparam logic [FLOOR_W-1:0] CURRENT_RESET = 5'd1;

  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [FLOOR_W-1:0] floor;
  } efs_in_t;

  typedef struct packed {
    logic               clear_valid;
    logic [FLOOR_W-1:0] clear_floor;
    logic               dispatch_valid;
    logic [FLOOR_W-1:0] dispatch_floor;
    logic               busy_out;
    logic [FLOOR_W-1:0] position;
    logic               bad_floor;
  } efs_out_t;

  typedef struct packed {
    logic               set_en;
    logic               clr_en;
    logic               trunc_en;
    logic               load;
    logic [FLOOR_W-1:0] sel;
    logic [FLOOR_W-1:0] cur;
    logic [FLOOR_W-1:0] cnt;
  } efs_cell_ctrl_t;

  typedef struct packed {
    logic up;
    logic dn;
  } efs_hit_t;

endpackage

// ----- hdl/elevator_floor_scheduler.sv -----
// elevator floor scheduler top level: event handling, scan control, result register
//
// in channel (in_valid/in_ready, in_data): one button or arrival event per item.
// out channel (out_valid/out_ready, out_data): exactly one result item per event.
// cfg_we/cfg_data write floors_in_use; write only while no event is in flight.
// request bits live in a row of MAX_FLOORS cells. a target search sends an up
// token and a down token from the cabin floor through the row, one floor per
// cycle, and the first requested cell each token meets gives the distance.
// events that need no search (bad floor, button for the cabin floor,
// button while busy) go from accept straight to the emit step; events that
// search pass through the load step, the token walk and the decide step first.
// one event is worked at a time; a new item can be taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// when the receiver stalls, the result holds and the next event waits in its
// final step until the output register frees up.
// reset: no requests, cabin at floor 1, standing by, floors_in_use = 16.
module elevator_floor_scheduler #(
  parameter int MAX_FLOORS = efs_pkg::MAX_FLOORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  efs_pkg::efs_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output efs_pkg::efs_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [efs_pkg::FLOOR_W-1:0]         cfg_data
);

  localparam int FW     = efs_pkg::FLOOR_W;
  localparam int CW     = efs_pkg::CMP_W;
  localparam int DIST_W = (MAX_FLOORS > 2) ? $clog2(MAX_FLOORS) : 1;
  localparam logic [DIST_W-1:0] LAST_DIST = DIST_W'(MAX_FLOORS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  function automatic logic [FW-1:0] clamp_cnt(input logic [FW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w < CW'(efs_pkg::MIN_FLOORS)) w = CW'(efs_pkg::MIN_FLOORS);
    if (w > CW'(MAX_FLOORS)) w = CW'(MAX_FLOORS);
    return FW'(w);
  endfunction

  logic [2:0]        state;
  logic [FW-1:0]     floors_in_use;
  logic [FW-1:0]     prev;
  logic [FW-1:0]     cur;
  logic [FW-1:0]     target;
  logic              busy;
  logic [DIST_W-1:0] k;
  logic              up_found;
  logic              dn_found;
  logic [DIST_W-1:0] up_dist;
  logic [DIST_W-1:0] dn_dist;
  logic              res_clr_v;
  logic [FW-1:0]     res_clr_f;
  logic              res_dsp_v;
  logic [FW-1:0]     res_dsp_f;
  logic              res_bad;

  logic                    accept;
  logic [FW-1:0]           cnt;
  logic                    is_bad;
  logic                    is_set;
  logic                    pick_v;
  logic [FW-1:0]           pick_f;
  logic [FW-1:0]           up_f;
  logic [FW-1:0]           dn_f;
  logic                    out_free;
  efs_pkg::efs_cell_ctrl_t cell_ctrl;
  efs_pkg::efs_hit_t       hit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cnt      = clamp_cnt(floors_in_use);

  assign is_bad = (in_data.floor == '0) || (CW'(in_data.floor) > CW'(cnt));
  assign is_set = (in_data.operation == efs_pkg::OP_BUTTON) && !is_bad && (in_data.floor != cur);

  always_comb begin
    cell_ctrl.set_en   = accept && is_set;
    cell_ctrl.clr_en   = accept && (in_data.operation == efs_pkg::OP_ARRIVE);
    cell_ctrl.trunc_en = cfg_we;
    cell_ctrl.load     = (state == ST_LOAD);
    cell_ctrl.sel      = (in_data.operation == efs_pkg::OP_ARRIVE) ? target : in_data.floor;
    cell_ctrl.cur      = cur;
    cell_ctrl.cnt      = cfg_we ? clamp_cnt(cfg_data) : cnt;
  end

  efs_chain #(
    .MAX_FLOORS(MAX_FLOORS)
  ) u_chain (
    .clk (clk),
    .rst (rst),
    .ctrl(cell_ctrl),
    .hit (hit)
  );

  assign up_f = FW'(CW'(cur) + CW'(up_dist));
  assign dn_f = FW'(CW'(cur) - CW'(dn_dist));

  // keep travel direction, reverse if nothing is ahead; at rest nearest wins, tie up
  always_comb begin
    pick_v = up_found || dn_found;
    if (prev < cur) begin
      pick_f = up_found ? up_f : dn_f;
    end else if (prev > cur) begin
      pick_f = dn_found ? dn_f : up_f;
    end else if (up_found && dn_found) begin
      pick_f = (dn_dist < up_dist) ? dn_f : up_f;
    end else begin
      pick_f = up_found ? up_f : dn_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      floors_in_use <= efs_pkg::FLOORS_RESET;
      prev          <= '0;
      cur           <= efs_pkg::CURRENT_RESET;
      target        <= efs_pkg::CURRENT_RESET;
      busy          <= 1'b0;
      k             <= '0;
      up_found      <= 1'b0;
      dn_found      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        floors_in_use <= cfg_data;
      end
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.operation == efs_pkg::OP_ARRIVE) begin
              prev  <= cur;
              cur   <= target;
              state <= ST_LOAD;
            end else if (is_set && !busy) begin
              state <= ST_LOAD;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_LOAD: begin
          k        <= DIST_W'(1);
          up_found <= 1'b0;
          dn_found <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (hit.up && !up_found) begin
            up_found <= 1'b1;
          end
          if (hit.dn && !dn_found) begin
            dn_found <= 1'b1;
          end
          if (k == LAST_DIST) begin
            state <= ST_DECIDE;
          end else begin
            k <= k + DIST_W'(1);
          end
        end
        ST_DECIDE: begin
          busy   <= pick_v;
          target <= pick_v ? pick_f : cur;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_bad   <= (in_data.operation == efs_pkg::OP_BUTTON) && is_bad;
      res_dsp_v <= 1'b0;
      res_dsp_f <= '0;
      if (in_data.operation == efs_pkg::OP_ARRIVE) begin
        res_clr_v <= 1'b1;
        res_clr_f <= target;
      end else if (!is_bad && (in_data.floor == cur)) begin
        res_clr_v <= 1'b1;
        res_clr_f <= in_data.floor;
      end else begin
        res_clr_v <= 1'b0;
        res_clr_f <= '0;
      end
    end
    if (state == ST_SCAN) begin
      if (hit.up && !up_found) begin
        up_dist <= k;
      end
      if (hit.dn && !dn_found) begin
        dn_dist <= k;
      end
    end
    if (state == ST_DECIDE) begin
      res_dsp_v <= pick_v;
      res_dsp_f <= pick_v ? pick_f : '0;
    end
    if ((state == ST_EMIT) && out_free) begin
      out_data.clear_valid    <= res_clr_v;
      out_data.clear_floor    <= res_clr_f;
      out_data.dispatch_valid <= res_dsp_v;
      out_data.dispatch_floor <= res_dsp_f;
      out_data.busy_out       <= busy;
      out_data.position       <= cur;
      out_data.bad_floor      <= res_bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_has_target: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && busy |-> (target != cur))
    else $error("busy with target equal to current floor");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && !busy |-> (target == cur))
    else $error("standing by away from target");

  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dispatch_valid |-> out_data.busy_out)
    else $error("dispatch while standing by");

  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_floor |-> !out_data.clear_valid && !out_data.dispatch_valid)
    else $error("ignored floor caused an action");
`endif

endmodule

// ----- hdl/efs_cell.sv -----
// one floor cell: request bit plus the up and down search tokens
module efs_cell #(
  parameter int FLOOR = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  efs_pkg::efs_cell_ctrl_t ctrl,
  input  logic                    up_in,
  input  logic                    dn_in,
  output logic                    up_tok,
  output logic                    dn_tok,
  output logic                    req
);

  localparam logic [efs_pkg::CMP_W-1:0] FL = efs_pkg::CMP_W'(FLOOR);

  logic [efs_pkg::CMP_W-1:0] sel_w;
  logic [efs_pkg::CMP_W-1:0] cur_w;
  logic [efs_pkg::CMP_W-1:0] cnt_w;

  assign sel_w = efs_pkg::CMP_W'(ctrl.sel);
  assign cur_w = efs_pkg::CMP_W'(ctrl.cur);
  assign cnt_w = efs_pkg::CMP_W'(ctrl.cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      req    <= 1'b0;
      up_tok <= 1'b0;
      dn_tok <= 1'b0;
    end else begin
      if (ctrl.trunc_en && (FL > cnt_w)) begin
        req <= 1'b0;
      end else if (ctrl.set_en && (sel_w == FL)) begin
        req <= 1'b1;
      end else if (ctrl.clr_en && (sel_w == FL)) begin
        req <= 1'b0;
      end
      // tokens start next to the cabin, then walk one floor per cycle
      if (ctrl.load) begin
        up_tok <= ((cur_w + efs_pkg::CMP_W'(1)) == FL);
        dn_tok <= (cur_w == (FL + efs_pkg::CMP_W'(1)));
      end else begin
        up_tok <= up_in;
        dn_tok <= dn_in;
      end
    end
  end

endmodule

// ----- hdl/efs_chain.sv -----
// row of floor cells with the token links between neighbors
module efs_chain #(
  parameter int MAX_FLOORS = efs_pkg::MAX_FLOORS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  efs_pkg::efs_cell_ctrl_t ctrl,
  output efs_pkg::efs_hit_t       hit
);

  logic [MAX_FLOORS-1:0] up_tok;
  logic [MAX_FLOORS-1:0] dn_tok;
  logic [MAX_FLOORS-1:0] req;

  for (genvar i = 0; i < MAX_FLOORS; i++) begin : g_cell
    logic up_in;
    logic dn_in;
    if (i == 0) begin : g_bot
      assign up_in = 1'b0;
    end else begin : g_upl
      assign up_in = up_tok[i-1];
    end
    if (i == MAX_FLOORS - 1) begin : g_top
      assign dn_in = 1'b0;
    end else begin : g_dnl
      assign dn_in = dn_tok[i+1];
    end
    efs_cell #(
      .FLOOR(i + 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .up_in (up_in),
      .dn_in (dn_in),
      .up_tok(up_tok[i]),
      .dn_tok(dn_tok[i]),
      .req   (req[i])
    );
  end

  assign hit.up = |(up_tok & req);
  assign hit.dn = |(dn_tok & req);

endmodule

// ----- bench/elevator_floor_scheduler_test.sv -----
`timescale 1ns / 1ps
// testbench for the elevator floor scheduler: event table and random events checked by a scan model
module elevator_floor_scheduler_test;

  localparam int NFLOORS = efs_pkg::MAX_FLOORS_DEF;
  localparam int PHASE_ITEMS = 140;
  localparam int NPHASES = 10;
  localparam int NSCRIPT = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 300;
  localparam int SETTLE_CYCLES = NFLOORS + 8;

  // typed results that follow straight from reset state
  localparam efs_pkg::efs_out_t BAD_AT_GROUND = '{1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 5'd1, 1'b1};
  localparam efs_pkg::efs_out_t CLEAR_GROUND  = '{1'b1, 5'd1, 1'b0, 5'd0, 1'b0, 5'd1, 1'b0};
  localparam efs_pkg::efs_out_t UNTYPED       = '0;

  typedef struct {
    logic                        op;
    logic [efs_pkg::FLOOR_W-1:0] fl;
    bit                          typed;
    efs_pkg::efs_out_t           want;
  } event_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  efs_pkg::efs_in_t            in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  efs_pkg::efs_out_t           out_data;
  logic                        cfg_we = 1'b0;
  logic [efs_pkg::FLOOR_W-1:0] cfg_data = '0;

  int errors = 0;
  int cycles = 0;
  efs_pkg::efs_out_t due_results[$];

  // scheduler model state
  logic [efs_pkg::FLOOR_W-1:0] floors_reg;
  logic [NFLOORS-1:0]          pending;
  logic [efs_pkg::FLOOR_W-1:0] last_floor;
  logic [efs_pkg::FLOOR_W-1:0] cabin_floor;
  logic [efs_pkg::FLOOR_W-1:0] goal_floor;
  logic                        moving;

  event_row_t script [NSCRIPT] = '{
    '{efs_pkg::OP_BUTTON, 5'd0,  1'b1, BAD_AT_GROUND},
    '{efs_pkg::OP_BUTTON, 5'd31, 1'b1, BAD_AT_GROUND},
    '{efs_pkg::OP_BUTTON, 5'd17, 1'b1, BAD_AT_GROUND},
    '{efs_pkg::OP_BUTTON, 5'd1,  1'b1, CLEAR_GROUND},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b1, CLEAR_GROUND},
    '{efs_pkg::OP_BUTTON, 5'd16, 1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd2,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd16, 1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd15, 1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd14, 1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd1,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd16, 1'b0, UNTYPED},
    '{efs_pkg::OP_BUTTON, 5'd0,  1'b0, UNTYPED},
    '{efs_pkg::OP_ARRIVE, 5'd31, 1'b0, UNTYPED}
  };

  logic [efs_pkg::FLOOR_W-1:0] floor_settings [NPHASES] = '{
    5'd16, 5'd2, 5'd0, 5'd31, 5'd7, 5'd1, 5'd12, 5'd17, 5'd9, 5'd16
  };

  elevator_floor_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
      $display("FAIL elevator_floor_scheduler");
      $finish;
    end
  end

  function automatic int served_floors();
    int n;
    n = floors_reg;
    if (n < efs_pkg::MIN_FLOORS) n = efs_pkg::MIN_FLOORS;
    if (n > NFLOORS) n = NFLOORS;
    return n;
  endfunction

  function automatic bit wanted(int f);
    if (f < 1 || f > NFLOORS) return 1'b0;
    return pending[f-1];
  endfunction

  function automatic int look_up();
    int f;
    for (f = int'(cabin_floor) + 1; f <= served_floors(); f++)
      if (wanted(f)) return f;
    return 0;
  endfunction

  function automatic int look_down();
    int f;
    f = (cabin_floor > 0) ? int'(cabin_floor) - 1 : 0;
    if (f > served_floors()) f = served_floors();
    for (; f >= 1; f--)
      if (wanted(f)) return f;
    return 0;
  endfunction

  // standing still: closest request, a tie goes up
  function automatic int look_nearest();
    int up;
    int dn;
    up = look_up();
    dn = look_down();
    if (up == 0) return dn;
    if (dn == 0) return up;
    return ((int'(cabin_floor) - dn) < (up - int'(cabin_floor))) ? dn : up;
  endfunction

  function automatic int pick_target();
    int t;
    if (last_floor < cabin_floor) t = look_up();
    else if (last_floor > cabin_floor) t = look_down();
    else t = look_nearest();
    if (t == 0) t = look_down();
    if (t == 0) t = look_up();
    if (t == 0) begin
      goal_floor = cabin_floor;
      moving = 1'b0;
    end else begin
      goal_floor = efs_pkg::FLOOR_W'(t);
      moving = 1'b1;
    end
    return t;
  endfunction

  function automatic efs_pkg::efs_out_t schedule_event(efs_pkg::efs_in_t ev);
    efs_pkg::efs_out_t r;
    int f;
    int t;
    r = '0;
    f = ev.floor;
    if (ev.operation == efs_pkg::OP_BUTTON) begin
      if (f < 1 || f > served_floors()) begin
        r.bad_floor = 1'b1;
      end else if (f != cabin_floor) begin
        pending[f-1] = 1'b1;
        if (!moving) begin
          t = pick_target();
          r.dispatch_valid = (t != 0);
          r.dispatch_floor = efs_pkg::FLOOR_W'(t);
        end
      end else begin
        r.clear_valid = 1'b1;
        r.clear_floor = efs_pkg::FLOOR_W'(f);
      end
    end else begin
      last_floor = cabin_floor;
      cabin_floor = goal_floor;
      if (cabin_floor >= 1 && cabin_floor <= NFLOORS) pending[cabin_floor-1] = 1'b0;
      r.clear_valid = 1'b1;
      r.clear_floor = cabin_floor;
      t = pick_target();
      r.dispatch_valid = (t != 0);
      r.dispatch_floor = efs_pkg::FLOOR_W'(t);
    end
    r.busy_out = moving;
    r.position = cabin_floor;
    return r;
  endfunction

  // mostly well-formed traffic, some bad floors and buttons at the cabin floor
  function automatic efs_pkg::efs_in_t random_event();
    efs_pkg::efs_in_t ev;
    int r;
    int n;
    n = served_floors();
    r = $urandom_range(0, 99);
    ev.operation = efs_pkg::OP_BUTTON;
    ev.floor = efs_pkg::FLOOR_W'($urandom_range(1, n));
    if (r < 38) begin
      ev.operation = efs_pkg::OP_ARRIVE;
      ev.floor = efs_pkg::FLOOR_W'($urandom);
    end else if (r < 46) begin
      ev.floor = ($urandom_range(0, 3) == 0) ? 5'd0 :
                 efs_pkg::FLOOR_W'($urandom_range(n + 1, 31));
    end else if (r < 54) begin
      ev.floor = cabin_floor;
    end
    return ev;
  endfunction

  // every fifth stretch of 50 items runs back to back
  function automatic int pause_for(int k);
    if ((k / 50) % 5 == 4) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_event(efs_pkg::efs_in_t ev, int gap, bit typed,
                            efs_pkg::efs_out_t typed_want);
    efs_pkg::efs_out_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = schedule_event(ev);
    if (typed) predicted = typed_want;
    due_results = {due_results, predicted};
  endtask

  task automatic write_floors(logic [efs_pkg::FLOOR_W-1:0] v);
    int f;
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    floors_reg = v;
    for (f = served_floors() + 1; f <= NFLOORS; f++) pending[f-1] = 1'b0;
  endtask

  initial begin : event_side
    efs_pkg::efs_in_t ev;
    int sent;
    floors_reg = efs_pkg::FLOORS_RESET;
    pending = '0;
    last_floor = '0;
    cabin_floor = efs_pkg::CURRENT_RESET;
    goal_floor = efs_pkg::CURRENT_RESET;
    moving = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (script[i]) begin
      ev.operation = script[i].op;
      ev.floor = script[i].fl;
      send_event(ev, pause_for(i), script[i].typed, script[i].want);
    end
    for (int p = 0; p < NPHASES; p++) begin
      write_floors(floor_settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_event(random_event(), pause_for(sent), 1'b0, UNTYPED);
        sent++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS elevator_floor_scheduler");
    end else begin
      $display("FAIL elevator_floor_scheduler");
    end
    $finish;
  end

  initial begin : result_side
    int stall;
    int taken;
    efs_pkg::efs_out_t want;
    taken = 0;
    forever begin
      // one long hold-off lets the block back up into its input
      stall = (taken == HOLD_AT) ? HOLD_CYCLES : pause_for(taken + 25);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, out_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        compare_field("clear_valid", want.clear_valid, out_data.clear_valid);
        compare_field("clear_floor", want.clear_floor, out_data.clear_floor);
        compare_field("dispatch_valid", want.dispatch_valid, out_data.dispatch_valid);
        compare_field("dispatch_floor", want.dispatch_floor, out_data.dispatch_floor);
        compare_field("busy_out", want.busy_out, out_data.busy_out);
        compare_field("position", want.position, out_data.position);
        compare_field("bad_floor", want.bad_floor, out_data.bad_floor);
      end
    end
  end

endmodule
